@@ hdl/nqt_pkg.sv @@
// ----------------------------------------------------------------------------
// nqt_pkg
// shared types, constants and list-match helper for the nested quote tokenizer
// ----------------------------------------------------------------------------
package nqt_pkg;

  localparam int unsigned MAX_NEST    = 255;
  localparam int unsigned NEST_W      = $clog2(MAX_NEST + 1);
  localparam int unsigned DELIM_SLOTS = 8;
  localparam int unsigned QUOTE_SLOTS = 4;
  localparam int unsigned SLOT_W      = (QUOTE_SLOTS > 1) ? $clog2(QUOTE_SLOTS) : 1;

  localparam int unsigned CFG_W       = 64;
  localparam int unsigned QSET_W      = 32;

  localparam int unsigned CMD_DEPTH   = 4;
  localparam int unsigned CMD_PTR_W   = $clog2(CMD_DEPTH);
  localparam int unsigned CMD_CNT_W   = $clog2(CMD_DEPTH + 1);
  localparam int unsigned OUT_DEPTH   = 4;
  localparam int unsigned OUT_PTR_W   = $clog2(OUT_DEPTH);
  localparam int unsigned OUT_CNT_W   = $clog2(OUT_DEPTH + 1);

  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_DQUOTE = 8'h22;

  localparam logic [CFG_W-1:0]  START_SKIP_RST  = CFG_W'(32);
  localparam logic [CFG_W-1:0]  END_DELIM_RST   = CFG_W'(32);
  localparam logic [QSET_W-1:0] QUOTE_OPEN_RST  = QSET_W'(34);
  localparam logic [QSET_W-1:0] QUOTE_CLOSE_RST = QSET_W'(34);

  typedef enum logic [1:0] {
    CFG_START_SKIP  = 2'd0,
    CFG_END_DELIM   = 2'd1,
    CFG_QUOTE_OPEN  = 2'd2,
    CFG_QUOTE_CLOSE = 2'd3
  } cfg_idx_e;

  typedef enum logic [2:0] {
    PH_SKIP   = 3'b001,
    PH_PLAIN  = 3'b010,
    PH_QUOTED = 3'b100
  } phase_e;

  typedef struct packed {
    logic [7:0] in_char;
    logic       string_end;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_char;
    logic       token_last;
  } out_item_t;

  // classified item handed from front to back
  typedef struct packed {
    logic [7:0]             ch;
    logic                   last;
    logic                   skip_hit;
    logic                   end_hit;
    logic [QUOTE_SLOTS-1:0] open_hit;
    logic [QUOTE_SLOTS-1:0] close_hit;
  } cls_t;

  // up to two result writes per cycle, packed toward slot 0
  typedef struct packed {
    logic      v0;
    out_item_t d0;
    logic      v1;
    out_item_t d1;
  } res_wr_t;

  // per-slot hits of c in a zero-terminated byte list
  function automatic logic [7:0] slot_hits(logic [CFG_W-1:0] set, int unsigned slots,
                                           logic [7:0] c);
    logic       alive;
    logic [7:0] hits;
    logic [7:0] b;
    alive = 1'b1;
    hits  = '0;
    for (int i = 0; i < 8; i++) begin
      b = set[8*i +: 8];
      if (i >= slots || b == 8'd0) alive = 1'b0;
      hits[i] = alive && (b == c);
    end
    return hits;
  endfunction

endpackage

@@ hdl/nqt_front.sv @@
// ----------------------------------------------------------------------------
// nqt_front
// configuration registers and per-character classification
// ----------------------------------------------------------------------------
module nqt_front
  import nqt_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  cfg_idx_e         cfg_idx_i,
  input  logic [CFG_W-1:0] cfg_data_i,
  input  logic             push_i,
  input  in_item_t         in_item_i,
  input  logic             q_full_i,
  output logic             wr_en_o,
  output cls_t             cls_o
);

  logic [CFG_W-1:0]  skip_set_q;
  logic [CFG_W-1:0]  end_set_q;
  logic [QSET_W-1:0] open_set_q;
  logic [QSET_W-1:0] close_set_q;
  logic [7:0]        open_hits;
  logic [7:0]        close_hits;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      skip_set_q  <= START_SKIP_RST;
      end_set_q   <= END_DELIM_RST;
      open_set_q  <= QUOTE_OPEN_RST;
      close_set_q <= QUOTE_CLOSE_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_START_SKIP:  skip_set_q  <= cfg_data_i;
        CFG_END_DELIM:   end_set_q   <= cfg_data_i;
        CFG_QUOTE_OPEN:  open_set_q  <= cfg_data_i[QSET_W-1:0];
        CFG_QUOTE_CLOSE: close_set_q <= cfg_data_i[QSET_W-1:0];
        default: ;
      endcase
    end
  end

  assign open_hits  = slot_hits(CFG_W'(open_set_q), QUOTE_SLOTS, in_item_i.in_char);
  assign close_hits = slot_hits(CFG_W'(close_set_q), QUOTE_SLOTS, in_item_i.in_char);

  always_comb begin
    cls_o.ch        = in_item_i.in_char;
    cls_o.last      = in_item_i.string_end;
    cls_o.skip_hit  = |slot_hits(skip_set_q, DELIM_SLOTS, in_item_i.in_char);
    cls_o.end_hit   = |slot_hits(end_set_q, DELIM_SLOTS, in_item_i.in_char);
    cls_o.open_hit  = open_hits[QUOTE_SLOTS-1:0];
    cls_o.close_hit = close_hits[QUOTE_SLOTS-1:0];
  end

  assign wr_en_o = push_i && !q_full_i;

endmodule

@@ hdl/nqt_cmd_fifo.sv @@
// ----------------------------------------------------------------------------
// nqt_cmd_fifo
// short queue of classified items between front and back
// ----------------------------------------------------------------------------
module nqt_cmd_fifo
  import nqt_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic wr_en_i,
  input  cls_t wr_data_i,
  input  logic rd_en_i,
  output cls_t rd_data_o,
  output logic full_o,
  output logic empty_o
);

  cls_t                 mem_q [CMD_DEPTH];
  logic [CMD_PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [CMD_PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CMD_CNT_W-1:0] cnt_q, cnt_d;
  logic                 do_wr, do_rd;

  assign full_o    = (cnt_q == CMD_CNT_W'(CMD_DEPTH));
  assign empty_o   = (cnt_q == '0);
  assign do_wr     = wr_en_i && !full_o;
  assign do_rd     = rd_en_i && !empty_o;
  assign rd_data_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = do_wr ? wr_ptr_q + CMD_PTR_W'(1) : wr_ptr_q;
    rd_ptr_d = do_rd ? rd_ptr_q + CMD_PTR_W'(1) : rd_ptr_q;
    cnt_d    = cnt_q + CMD_CNT_W'(do_wr) - CMD_CNT_W'(do_rd);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

endmodule

@@ hdl/nqt_back.sv @@
// ----------------------------------------------------------------------------
// nqt_back
// tokenizer state machine: skipping, quoting, nesting and one-behind output
// ----------------------------------------------------------------------------
module nqt_back
  import nqt_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    cmd_empty_i,
  input  cls_t    cmd_i,
  input  logic    out_room_i,
  output logic    cmd_pop_o,
  output res_wr_t res_o
);

  phase_e            phase_q, phase_d;
  logic [SLOT_W-1:0] slot_q, slot_d;
  logic [NEST_W-1:0] nest_q, nest_d;
  logic              bs_q, bs_d;
  logic [7:0]        held_q, held_d;
  logic              hv_q, hv_d;

  logic              q_any;
  logic [SLOT_W-1:0] q_idx;
  logic              is_bs;
  logic              e0_v, e1_v;
  out_item_t         e0, e1;
  logic              fin;

  assign cmd_pop_o = !cmd_empty_i && out_room_i;
  assign q_any     = |cmd_i.open_hit;
  assign is_bs     = (cmd_i.ch == CH_BSLASH);

  // lowest matching open slot
  always_comb begin
    q_idx = '0;
    for (int i = QUOTE_SLOTS - 1; i >= 0; i--) begin
      if (cmd_i.open_hit[i]) q_idx = SLOT_W'(i);
    end
  end

  always_comb begin
    phase_d = phase_q;
    slot_d  = slot_q;
    nest_d  = nest_q;
    bs_d    = bs_q;
    held_d  = held_q;
    hv_d    = hv_q;
    e0_v    = 1'b0;
    e0      = '{out_char: held_q, token_last: 1'b0};
    e1_v    = 1'b0;
    e1      = '{out_char: cmd_i.ch, token_last: 1'b1};
    fin     = 1'b0;
    if (cmd_pop_o) begin
      unique case (phase_q)
        PH_PLAIN: begin
          if (cmd_i.end_hit) begin
            e1_v    = hv_q;
            e1      = '{out_char: held_q, token_last: 1'b1};
            hv_d    = 1'b0;
            phase_d = PH_SKIP;
            slot_d  = '0;
            nest_d  = '0;
            bs_d    = 1'b0;
          end else begin
            e0_v   = hv_q && !(held_q == CH_BSLASH && cmd_i.ch == CH_DQUOTE);
            held_d = cmd_i.ch;
            hv_d   = 1'b1;
            if (q_any) begin
              phase_d = PH_QUOTED;
              slot_d  = q_idx;
              nest_d  = NEST_W'(1);
              bs_d    = 1'b0;
            end else begin
              bs_d = is_bs;
            end
            fin = cmd_i.last;
          end
        end
        PH_QUOTED: begin
          if (!bs_q && cmd_i.close_hit[slot_q]) begin
            if (nest_q != '0) nest_d = nest_q - NEST_W'(1);
          end else if (!bs_q && cmd_i.open_hit[slot_q]) begin
            if (nest_q < NEST_W'(MAX_NEST)) nest_d = nest_q + NEST_W'(1);
          end
          e0_v    = hv_q && !(held_q == CH_BSLASH && cmd_i.ch == CH_DQUOTE);
          held_d  = cmd_i.ch;
          hv_d    = 1'b1;
          bs_d    = is_bs;
          phase_d = (nest_d == '0) ? PH_PLAIN : PH_QUOTED;
          fin     = cmd_i.last;
        end
        default: begin
          // skipping, and any unused phase code
          if (!q_any && cmd_i.skip_hit) begin
            hv_d    = 1'b0;
            phase_d = PH_SKIP;
          end else begin
            held_d = cmd_i.ch;
            hv_d   = 1'b1;
            if (q_any) begin
              phase_d = PH_QUOTED;
              slot_d  = q_idx;
              nest_d  = NEST_W'(1);
              bs_d    = 1'b0;
            end else begin
              phase_d = PH_PLAIN;
              bs_d    = is_bs;
            end
            fin = cmd_i.last;
          end
        end
      endcase
      if (fin) begin
        e1_v    = 1'b1;
        e1      = '{out_char: cmd_i.ch, token_last: 1'b1};
        hv_d    = 1'b0;
        phase_d = PH_SKIP;
        slot_d  = '0;
        nest_d  = '0;
        bs_d    = 1'b0;
      end
    end
  end

  // pack results toward slot 0
  always_comb begin
    res_o.v0 = e0_v || e1_v;
    res_o.d0 = e0_v ? e0 : e1;
    res_o.v1 = e0_v && e1_v;
    res_o.d1 = e1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_SKIP;
      slot_q  <= '0;
      nest_q  <= '0;
      bs_q    <= 1'b0;
      held_q  <= '0;
      hv_q    <= 1'b0;
    end else begin
      phase_q <= phase_d;
      slot_q  <= slot_d;
      nest_q  <= nest_d;
      bs_q    <= bs_d;
      held_q  <= held_d;
      hv_q    <= hv_d;
    end
  end

endmodule

@@ hdl/nqt_out_fifo.sv @@
// ----------------------------------------------------------------------------
// nqt_out_fifo
// result queue: up to two writes and one read per cycle
// ----------------------------------------------------------------------------
module nqt_out_fifo
  import nqt_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  res_wr_t   wr_i,
  input  logic      pop_i,
  output out_item_t rd_data_o,
  output logic      empty_o,
  output logic      room2_o
);

  out_item_t            mem_q [OUT_DEPTH];
  logic [OUT_PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [OUT_PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [OUT_CNT_W-1:0] cnt_q, cnt_d;
  logic                 do_rd;
  logic [OUT_PTR_W-1:0] wr_ptr_nx;

  assign empty_o   = (cnt_q == '0);
  assign room2_o   = (cnt_q <= OUT_CNT_W'(OUT_DEPTH - 2));
  assign do_rd     = pop_i && !empty_o;
  assign rd_data_o = mem_q[rd_ptr_q];
  assign wr_ptr_nx = wr_ptr_q + OUT_PTR_W'(1);

  always_comb begin
    wr_ptr_d = wr_ptr_q + OUT_PTR_W'(wr_i.v0) + OUT_PTR_W'(wr_i.v1);
    rd_ptr_d = do_rd ? rd_ptr_q + OUT_PTR_W'(1) : rd_ptr_q;
    cnt_d    = cnt_q + OUT_CNT_W'(wr_i.v0) + OUT_CNT_W'(wr_i.v1) - OUT_CNT_W'(do_rd);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i.v0) begin
      mem_q[wr_ptr_q] <= wr_i.d0;
    end
    if (wr_i.v1) begin
      mem_q[wr_ptr_nx] <= wr_i.d1;
    end
  end

endmodule

@@ hdl/nested_quote_tokenizer_core.sv @@
// ----------------------------------------------------------------------------
// nested_quote_tokenizer_core
// streaming string tokenizer with nested quoting and escape collapsing
// ----------------------------------------------------------------------------
// results: a result enters the result queue in the same cycle its completing item is taken
// throughput: one item per cycle; the back takes one queued item per cycle while the
//   result queue has room for two, and an item giving two results needs two consumer pops
// reset: asynchronous, active low; delimiter sets go to space/space/dquote/dquote,
//   both queues empty, tokenizer back in the skipping phase
module nested_quote_tokenizer_core
  import nqt_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  // configuration writes
  input  logic             cfg_we_i,
  input  cfg_idx_e         cfg_idx_i,
  input  logic [CFG_W-1:0] cfg_data_i,
  // input item side
  input  logic             push,
  input  in_item_t         in_item_i,
  output logic             full,
  // result item side
  output logic             empty,
  input  logic             pop,
  output out_item_t        out_item_o
);

  // front to queue
  logic    cmd_wr;
  cls_t    cmd_wdata;
  // queue to back
  cls_t    cmd_head;
  logic    cmd_empty;
  logic    cmd_pop;
  // back to result queue
  res_wr_t res_wr;
  logic    out_room;

  // front: config registers and list compares on the incoming char
  nqt_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .push_i     (push),
    .in_item_i  (in_item_i),
    .q_full_i   (full),
    .wr_en_o    (cmd_wr),
    .cls_o      (cmd_wdata)
  );

  // decoupling queue of classified items
  nqt_cmd_fifo u_cmd_fifo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (cmd_wr),
    .wr_data_i (cmd_wdata),
    .rd_en_i   (cmd_pop),
    .rd_data_o (cmd_head),
    .full_o    (full),
    .empty_o   (cmd_empty)
  );

  // back: phase, nesting and the one-behind held char
  nqt_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_empty_i (cmd_empty),
    .cmd_i       (cmd_head),
    .out_room_i  (out_room),
    .cmd_pop_o   (cmd_pop),
    .res_o       (res_wr)
  );

  // result queue seen by the consumer
  nqt_out_fifo u_out_fifo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_i      (res_wr),
    .pop_i     (pop),
    .rd_data_o (out_item_o),
    .empty_o   (empty),
    .room2_o   (out_room)
  );

endmodule
